// File: src/psd_pkg.sv
// shared types and constants for the point to segment distance core
package psd_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIST_WIDTH = 25;
  // coordinate difference width
  localparam int DW = COORD_BITS + 1;
  // sum of two products
  localparam int PW = 2 * DW + 1;
  // cross product magnitude width and its split for squaring
  localparam int CW = PW;
  localparam int HW = (CW + 1) / 2;

  typedef enum logic [1:0] {
    REG_START    = 2'd0,
    REG_INTERIOR = 2'd1,
    REG_END      = 2'd2
  } region_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;
  } in_item_t;

  typedef struct packed {
    logic [DIST_WIDTH-1:0] distance;
    region_t               region;
    logic                  degenerate;
  } out_item_t;

  // sideband carried along the root chain
  typedef struct packed {
    region_t region;
    logic    degen;
  } psd_side_t;

endpackage

// File: src/psd_front.sv
// front pipeline: differences, products, region test and root operands
module psd_front import psd_pkg::*; #(
  parameter int FRAC_BITS = 8,
  parameter int BW        = 2 * CW + 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  in_item_t          in_item,
  output logic              out_valid,
  output psd_side_t         out_side,
  output logic [BW-1:0]     out_bound,
  output logic [PW-1:0]     out_scale
);

  // stage 1 registers
  logic                 v1_r;
  logic signed [DW-1:0] dx_r, dy_r, px_r, py_r, qx_r, qy_r;
  // stage 2 registers
  logic                   v2_r;
  logic signed [2*DW-1:0] dxdx_r, dydy_r, pxdx_r, pydy_r, pxdy_r, pydx_r;
  logic signed [2*DW-1:0] pxpx_r, pypy_r, qxqx_r, qyqy_r;
  // stage 3 registers
  logic                 v3_r;
  logic [PW-1:0]        len2_r, sqp_r, sqe_r;
  logic signed [PW-1:0] dot_r, cross_r;
  // stage 4 registers
  logic                    v4_r;
  psd_side_t               side4_r;
  logic [PW-1:0]           sq4_r, len4_r;
  logic [2*(CW-HW)-1:0]    hh_r;
  logic [CW-1:0]           hl_r;
  logic [2*HW-1:0]         ll_r;
  // stage 5 registers
  logic                    v5_r;
  psd_side_t               side5_r;
  logic [BW-1:0]           bound_r;
  logic [PW-1:0]           scale_r;

  logic [CW-1:0]        cr_mag;
  psd_side_t            side_nxt;
  logic [PW-1:0]        sq_nxt;
  logic [2*CW-1:0]      crsq;

  // region decision and cross magnitude
  always_comb begin
    cr_mag = cross_r[PW-1] ? CW'(-cross_r) : CW'(cross_r);
    side_nxt.degen  = (len2_r == '0);
    sq_nxt = sqp_r;
    if (len2_r == '0 || dot_r < 0) begin
      side_nxt.region = REG_START;
    end else if ($signed({1'b0, len2_r}) < $signed({dot_r[PW-1], dot_r})) begin
      side_nxt.region = REG_END;
      sq_nxt = sqe_r;
    end else begin
      side_nxt.region = REG_INTERIOR;
    end
  end

  // squared cross product from partial products
  assign crsq = ((2*CW)'(hh_r) << (2*HW)) + ((2*CW)'(hl_r) << (HW+1)) + (2*CW)'(ll_r);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    dx_r <= DW'(in_item.end_x) - DW'(in_item.start_x);
    dy_r <= DW'(in_item.end_y) - DW'(in_item.start_y);
    px_r <= DW'(in_item.query_x) - DW'(in_item.start_x);
    py_r <= DW'(in_item.query_y) - DW'(in_item.start_y);
    qx_r <= DW'(in_item.query_x) - DW'(in_item.end_x);
    qy_r <= DW'(in_item.query_y) - DW'(in_item.end_y);

    dxdx_r <= dx_r * dx_r;
    dydy_r <= dy_r * dy_r;
    pxdx_r <= px_r * dx_r;
    pydy_r <= py_r * dy_r;
    pxdy_r <= px_r * dy_r;
    pydx_r <= py_r * dx_r;
    pxpx_r <= px_r * px_r;
    pypy_r <= py_r * py_r;
    qxqx_r <= qx_r * qx_r;
    qyqy_r <= qy_r * qy_r;

    len2_r  <= PW'(unsigned'(dxdx_r)) + PW'(unsigned'(dydy_r));
    sqp_r   <= PW'(unsigned'(pxpx_r)) + PW'(unsigned'(pypy_r));
    sqe_r   <= PW'(unsigned'(qxqx_r)) + PW'(unsigned'(qyqy_r));
    dot_r   <= PW'(pxdx_r) + PW'(pydy_r);
    cross_r <= PW'(pxdy_r) - PW'(pydx_r);

    side4_r <= side_nxt;
    sq4_r   <= sq_nxt;
    len4_r  <= len2_r;
    hh_r    <= cr_mag[CW-1:HW] * cr_mag[CW-1:HW];
    hl_r    <= cr_mag[CW-1:HW] * cr_mag[HW-1:0];
    ll_r    <= cr_mag[HW-1:0] * cr_mag[HW-1:0];

    side5_r <= side4_r;
    if (side4_r.region == REG_INTERIOR) begin
      bound_r <= BW'(crsq) << (2*FRAC_BITS);
      scale_r <= len4_r;
    end else begin
      bound_r <= BW'(sq4_r) << (2*FRAC_BITS);
      scale_r <= PW'(1);
    end
  end

  assign out_valid = v5_r;
  assign out_side  = side5_r;
  assign out_bound = bound_r;
  assign out_scale = scale_r;

endmodule

// File: src/psd_cell.sv
// one cell of the root chain: decides one result bit
module psd_cell import psd_pkg::*; #(
  parameter int BIT = 0,
  parameter int SB  = 26,
  parameter int BW  = 86,
  parameter int TW  = 88
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  psd_side_t         in_side,
  input  logic [BW-1:0]     in_rem,
  input  logic [SB+PW-1:0]  in_acc,
  input  logic [PW-1:0]     in_scale,
  input  logic [SB-1:0]     in_root,
  output logic              out_valid,
  output psd_side_t         out_side,
  output logic [BW-1:0]     out_rem,
  output logic [SB+PW-1:0]  out_acc,
  output logic [PW-1:0]     out_scale,
  output logic [SB-1:0]     out_root
);

  logic [TW-1:0] term;
  logic          fits;
  logic          valid_r;
  psd_side_t     side_r;
  logic [BW-1:0]     rem_r;
  logic [SB+PW-1:0]  acc_r;
  logic [PW-1:0]     scale_r;
  logic [SB-1:0]     root_r;

  // growth of root^2 * scale when this bit is set
  always_comb begin
    term = (TW'(in_acc) << (BIT + 1)) + (TW'(in_scale) << (2 * BIT));
    fits = (term <= TW'(in_rem));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    side_r  <= in_side;
    scale_r <= in_scale;
    if (fits) begin
      rem_r  <= in_rem - BW'(term);
      acc_r  <= in_acc + ((SB+PW)'(in_scale) << BIT);
      root_r <= in_root | (SB'(1) << BIT);
    end else begin
      rem_r  <= in_rem;
      acc_r  <= in_acc;
      root_r <= in_root;
    end
  end

  assign out_valid = valid_r;
  assign out_side  = side_r;
  assign out_rem   = rem_r;
  assign out_acc   = acc_r;
  assign out_scale = scale_r;
  assign out_root  = root_r;

endmodule

// File: src/point_segment_distance_core.sv
// top level of the point to segment distance core
//
// Usage: present a segment (start, end) and a query point on in_item and
// raise start; the item is taken at any edge where start is high and busy
// is low. busy is always low, so one item may enter every cycle.
// Each result appears on out_item for one cycle with out_valid high and
// must be taken then; results leave in the order items entered.
// Five front stages do differences, products, region test and squaring of
// the cross product, then one cell per result bit does the root search.
// Throughput is one item per cycle, set by the fully pipelined cell row.
// distance is the truncated distance with FRAC_BITS fraction bits; region
// says which part of the segment is nearest; degenerate flags a
// zero-length segment, measured to the start point.
// Synchronous reset clears all valid bits; items in flight are dropped.
module point_segment_distance_core import psd_pkg::*; #(
  parameter int FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int SB  = COORD_BITS + FRAC_BITS + 2;
  localparam int BW  = 2 * CW + 2 * FRAC_BITS;
  localparam int TWA = 2 * SB + PW + 1;
  localparam int TW  = (TWA > BW) ? TWA : BW + 1;

  logic              vld_s   [SB+1];
  psd_side_t         side_s  [SB+1];
  logic [BW-1:0]     rem_s   [SB+1];
  logic [SB+PW-1:0]  acc_s   [SB+1];
  logic [PW-1:0]     scale_s [SB+1];
  logic [SB-1:0]     root_s  [SB+1];

  assign busy = 1'b0;

  psd_front #(
    .FRAC_BITS (FRAC_BITS),
    .BW        (BW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_item   (in_item),
    .out_valid (vld_s[0]),
    .out_side  (side_s[0]),
    .out_bound (rem_s[0]),
    .out_scale (scale_s[0])
  );

  assign acc_s[0]  = '0;
  assign root_s[0] = '0;

  // root search row, most significant bit first
  for (genvar i = 0; i < SB; i++) begin : g_cell
    psd_cell #(
      .BIT (SB - 1 - i),
      .SB  (SB),
      .BW  (BW),
      .TW  (TW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld_s[i]),
      .in_side   (side_s[i]),
      .in_rem    (rem_s[i]),
      .in_acc    (acc_s[i]),
      .in_scale  (scale_s[i]),
      .in_root   (root_s[i]),
      .out_valid (vld_s[i+1]),
      .out_side  (side_s[i+1]),
      .out_rem   (rem_s[i+1]),
      .out_acc   (acc_s[i+1]),
      .out_scale (scale_s[i+1]),
      .out_root  (root_s[i+1])
    );
  end

  assign out_valid           = vld_s[SB];
  assign out_item.distance   = DIST_WIDTH'(root_s[SB]);
  assign out_item.region     = side_s[SB].region;
  assign out_item.degenerate = side_s[SB].degen;

endmodule

// File: src/psd_checker.sv
// port checker for the point to segment distance core
module psd_checker import psd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // the core always takes items
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // region code three never appears
  a_region_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.region == REG_START || out_item.region == REG_INTERIOR ||
                   out_item.region == REG_END))
    else $error("bad region");

  // a zero-length segment is always measured to the start point
  a_degen_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.degenerate) |-> (out_item.region == REG_START))
    else $error("degenerate item not at start region");

  // no result in the cycle after reset releases
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind point_segment_distance_core psd_checker u_psd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// File: tb/point_segment_distance_core_tb.sv
// testbench for the point to segment distance core: directed and random items
`timescale 1ns / 100ps

module point_segment_distance_core_tb;
  import psd_pkg::*;

  localparam int FRAC = 8;
  localparam int LATENCY = 5 + COORD_BITS + FRAC + 2;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  out_item_t expected_q[$];
  int        error_count;
  int        cycle_count;
  int        idle_pct;

  point_segment_distance_core #(.FRAC_BITS(FRAC)) u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("point_segment_distance_core test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // largest v with v*v*scale <= bound
  function automatic longint unsigned floor_root(input logic [127:0] bound,
                                                 input logic [63:0] scale);
    logic [63:0]  v;
    logic [63:0]  c;
    logic [127:0] prod;
    v = '0;
    for (int b = COORD_BITS + FRAC + 1; b >= 0; b--) begin
      c = v | (64'd1 << b);
      prod = 128'(c) * 128'(c) * 128'(scale);
      if (prod <= bound) v = c;
    end
    return v;
  endfunction

  function automatic longint unsigned span_length(input longint ax, input longint ay);
    logic [127:0] sq;
    sq = 128'(ax * ax + ay * ay) << (2 * FRAC);
    return floor_root(sq, 64'd1);
  endfunction

  // expected distance, region and degenerate flag for one item
  function automatic out_item_t distance_of(input in_item_t it);
    longint sx, sy, ex, ey, qx, qy, dx, dy, px, py, len2, dot, cr;
    longint unsigned d;
    out_item_t r;
    sx = it.start_x; sy = it.start_y; ex = it.end_x; ey = it.end_y;
    qx = it.query_x; qy = it.query_y;
    dx = ex - sx; dy = ey - sy; px = qx - sx; py = qy - sy;
    len2 = dx * dx + dy * dy;
    dot = px * dx + py * dy;
    r.degenerate = 1'b0;
    if (len2 == 0) begin
      r.degenerate = 1'b1;
      r.region = REG_START;
      d = span_length(px, py);
    end else if (dot < 0) begin
      r.region = REG_START;
      d = span_length(px, py);
    end else if (dot > len2) begin
      r.region = REG_END;
      d = span_length(qx - ex, qy - ey);
    end else begin
      cr = px * dy - py * dx;
      if (cr < 0) cr = -cr;
      r.region = REG_INTERIOR;
      d = floor_root((128'(cr) * 128'(cr)) << (2 * FRAC), 64'(len2));
    end
    r.distance = d[DIST_WIDTH-1:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = expected_q.pop_front();
        if (out_item.distance !== want.distance)
          report_mismatch($sformatf("distance %0d, expected %0d",
                                    out_item.distance, want.distance));
        if (out_item.region !== want.region)
          report_mismatch($sformatf("region %0d, expected %0d",
                                    out_item.region, want.region));
        if (out_item.degenerate !== want.degenerate)
          report_mismatch($sformatf("degenerate %0b, expected %0b",
                                    out_item.degenerate, want.degenerate));
      end
    end
  end

  // send one item, with random idle cycles before it
  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(distance_of(it));
  endtask

  function automatic in_item_t make_item(input int sx, sy, ex, ey, qx, qy);
    in_item_t it;
    it.start_x = COORD_BITS'(sx); it.start_y = COORD_BITS'(sy);
    it.end_x   = COORD_BITS'(ex); it.end_y   = COORD_BITS'(ey);
    it.query_x = COORD_BITS'(qx); it.query_y = COORD_BITS'(qy);
    return it;
  endfunction

  function automatic logic [15:0] pick_coord(input int span);
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 16'h8000 : 16'h7fff;
    if (span == 0) return 16'($urandom);
    return 16'($signed(16'($urandom_range(2 * span))) - span);
  endfunction

  // extremes of the coordinates and each region and special case
  task automatic test_directed();
    idle_pct = 0;
    send_item(make_item(0, 0, 10, 0, 5, 3));
    send_item(make_item(0, 0, 10, 0, -4, 3));
    send_item(make_item(0, 0, 10, 0, 14, -3));
    send_item(make_item(0, 0, 10, 0, 10, 7));
    send_item(make_item(0, 0, 10, 0, 0, 0));
    send_item(make_item(5, 5, 5, 5, 8, 9));
    send_item(make_item(-32768, -32768, -32768, -32768, 32767, 32767));
    send_item(make_item(-32768, -32768, 32767, 32767, 32767, -32768));
    send_item(make_item(-32768, -32768, 32767, 32767, -32768, 32767));
    send_item(make_item(32767, -32768, -32768, 32767, 32767, 32767));
    send_item(make_item(-32768, 0, 32767, 0, 0, 32767));
    send_item(make_item(-32768, -32768, -32767, -32768, 32767, 32767));
    send_item(make_item(32767, 32767, -32768, -32768, 32767, 32767));
    send_item(make_item(-1, -1, -1, -1, -1, -1));
    send_item(make_item(0, 0, 3, 4, 7, 1));
    send_item(make_item(1, 2, 4, 6, 2, 9));
  endtask

  // random items under one idling rate
  task automatic test_random(input int count, input int pct);
    int span;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(3))
        0: span = 16;
        1: span = 300;
        2: span = 0;
        default: span = 4000;
      endcase
      if ($urandom_range(19) == 0)
        send_item({pick_coord(span), pick_coord(span), 16'h0000, 16'h0000,
                   pick_coord(span), pick_coord(span)});
      else
        send_item({pick_coord(span), pick_coord(span), pick_coord(span),
                   pick_coord(span), pick_coord(span), pick_coord(span)});
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_item     = '0;
    error_count = 0;
    cycle_count = 0;
    idle_pct    = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(300, 0);
    test_random(220, 76);
    test_random(200, 0);
    test_random(180, 9);
    start <= 1'b0;

    // drain the pipeline
    while (expected_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (error_count == 0) begin
      $display("point_segment_distance_core test passed");
    end else begin
      $display("point_segment_distance_core test failed");
    end
    $finish;
  end

endmodule
